/* design/cdcn_pkg.sv */
// Shared types, codes and exponent tables for the cepstral codebook normalizer.
`default_nettype none
package cdcn_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD_COEF   = 2'd0,
    FUNC_LOAD_WEIGHT = 2'd1,
    FUNC_LOAD_TILT   = 2'd2,
    FUNC_FRAME       = 2'd3
  } func_e;

  localparam logic [1:0] CFG_ACTIVE_CODES = 2'd0;
  localparam logic [1:0] CFG_ENABLE       = 2'd1;
  localparam logic [1:0] CFG_STATS_READY  = 2'd2;

  localparam int unsigned DIV_DW = 64;
  localparam int unsigned DIV_VW = 40;

  typedef struct packed {
    logic wr_tab;
    logic wr_wt;
    logic wr_tilt;
    logic wr_frame;
    logic clr;
    logic rd;
    logic sq_en;
    logic div_term;
    logic div_out;
    logic dist_add;
    logic exp_en;
    logic fk_en;
    logic ws_add;
    logic prod_en;
    logic acc_add;
    logic j_inc;
    logic j_clr;
    logic k_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic en;
    logic ws_zero;
    logic j_last;
    logic k_zero;
    logic k_last;
    logic div_done;
    logic out_free;
  } stat_t;

  // Round a Q.16-scaled product back to Q.16, ties away from zero.
  function automatic logic signed [63:0] round16(input logic signed [63:0] v);
    logic signed [63:0] m;
    begin
      if (v >= 0) begin
        round16 = (v + 64'sd32768) >>> 16;
      end else begin
        m = -v;
        round16 = -((m + 64'sd32768) >>> 16);
      end
    end
  endfunction

  // exp(-i) in Q1.16 for the integer part of the exponent.
  function automatic logic [16:0] exp_int(input logic [3:0] i);
    begin
      case (i)
        4'd0:    exp_int = 17'd65536;
        4'd1:    exp_int = 17'd24109;
        4'd2:    exp_int = 17'd8869;
        4'd3:    exp_int = 17'd3263;
        4'd4:    exp_int = 17'd1200;
        4'd5:    exp_int = 17'd442;
        4'd6:    exp_int = 17'd162;
        4'd7:    exp_int = 17'd60;
        4'd8:    exp_int = 17'd22;
        4'd9:    exp_int = 17'd8;
        4'd10:   exp_int = 17'd3;
        4'd11:   exp_int = 17'd1;
        default: exp_int = 17'd0;
      endcase
    end
  endfunction

  // exp(-f/16) in Q1.16 for the top four fraction bits.
  function automatic logic [16:0] exp_frac(input logic [3:0] f);
    begin
      case (f)
        4'd0:    exp_frac = 17'd65536;
        4'd1:    exp_frac = 17'd61565;
        4'd2:    exp_frac = 17'd57835;
        4'd3:    exp_frac = 17'd54331;
        4'd4:    exp_frac = 17'd51039;
        4'd5:    exp_frac = 17'd47947;
        4'd6:    exp_frac = 17'd45042;
        4'd7:    exp_frac = 17'd42313;
        4'd8:    exp_frac = 17'd39750;
        4'd9:    exp_frac = 17'd37341;
        4'd10:   exp_frac = 17'd35079;
        4'd11:   exp_frac = 17'd32954;
        4'd12:   exp_frac = 17'd30957;
        4'd13:   exp_frac = 17'd29082;
        4'd14:   exp_frac = 17'd27319;
        default: exp_frac = 17'd25664;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

/* design/cdcn_ram.sv */
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module cdcn_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/cdcn_div.sv */
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
`default_nettype none
module cdcn_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 40
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic      [DW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(DW);

  logic [VW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [VW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? VW'(rem_sh - {1'b0, dvs_q}) : rem_sh[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

/* design/cdcn_dp.sv */
// Datapath: codebook memories, frame buffer, distance, weight and estimate arithmetic.
`default_nettype none
module cdcn_dp #(
  parameter int unsigned COEFFS    = 13,
  parameter int unsigned MAX_CODES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cdcn_pkg::cmd_t      cmd_i,
  output cdcn_pkg::stat_t          stat_o,
  input  wire logic                en_i,
  input  wire logic [6:0]          active_codes_i,
  input  wire logic [5:0]          code_index_i,
  input  wire logic [3:0]          coef_index_i,
  input  wire logic signed [23:0]  value_a_i,
  input  wire logic signed [23:0]  value_b_i,
  input  wire logic [23:0]         value_c_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [3:0]               out_index_o,
  output logic signed [23:0]       out_value_o,
  output logic                     out_last_o
);

  localparam int unsigned CW     = $clog2(COEFFS);
  localparam int unsigned KW     = $clog2(MAX_CODES);
  localparam int unsigned DEPTH  = MAX_CODES * COEFFS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DIST_W = 52 + $clog2(COEFFS);

  // Codebook storage.
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [71:0]   tab_rdata;
  logic [23:0]   wt_rdata;
  logic [8:0]    code_ext;

  assign tab_waddr = AW'(32'(code_index_i) * 32'(COEFFS) + 32'(coef_index_i));
  assign code_ext  = {3'b000, code_index_i};

  logic [AW-1:0] base_q;
  logic [CW-1:0] j_q;
  logic [KW-1:0] k_q;

  assign tab_raddr = base_q + AW'(j_q);

  cdcn_ram #(.WIDTH(72), .DEPTH(DEPTH)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_tab),
    .waddr_i (tab_waddr),
    .wdata_i ({value_a_i, value_b_i, value_c_i}),
    .re_i    (cmd_i.rd),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  cdcn_ram #(.WIDTH(24), .DEPTH(MAX_CODES)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_wt),
    .waddr_i (code_ext[KW-1:0]),
    .wdata_i (value_a_i),
    .re_i    (cmd_i.rd),
    .raddr_i (k_q),
    .rdata_o (wt_rdata)
  );

  logic signed [23:0] mean_r, corr_r, wt_r;
  logic [23:0]        var_r;

  assign mean_r = tab_rdata[71:48];
  assign corr_r = tab_rdata[47:24];
  assign var_r  = tab_rdata[23:0];
  assign wt_r   = wt_rdata;

  // Tilt and frame buffer registers.
  logic signed [23:0] tilt_q  [COEFFS];
  logic signed [23:0] frame_q [COEFFS];
  logic [CW-1:0]      coef_sel;

  assign coef_sel = CW'(coef_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tilt) begin
      tilt_q[coef_sel] <= value_a_i;
    end
    if (cmd_i.wr_frame) begin
      frame_q[coef_sel] <= value_a_i;
    end
  end

  logic signed [23:0] z, t;
  assign z = frame_q[j_q];
  assign t = tilt_q[j_q];

  // Counters.
  logic [8:0]    nm1_w;
  logic [KW-1:0] nm1;

  always_comb begin
    if (active_codes_i == 7'd0) begin
      nm1_w = 9'd0;
    end else if (9'(active_codes_i) > 9'(MAX_CODES)) begin
      nm1_w = 9'(MAX_CODES - 1);
    end else begin
      nm1_w = 9'(active_codes_i) - 9'd1;
    end
  end
  assign nm1 = nm1_w[KW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q    <= '0;
      k_q    <= '0;
      base_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        j_q    <= '0;
        k_q    <= '0;
        base_q <= '0;
      end else begin
        if (cmd_i.j_clr) begin
          j_q <= '0;
        end else if (cmd_i.j_inc) begin
          j_q <= j_q + 1'b1;
        end
        if (cmd_i.k_inc) begin
          k_q    <= k_q + 1'b1;
          base_q <= base_q + AW'(COEFFS);
        end
      end
    end
  end

  // Distance term: squared difference.
  logic signed [25:0] d;
  logic [25:0]        mag;
  logic [51:0]        sq_q;

  assign d   = 26'(z) - 26'(t) - 26'(mean_r) - 26'(corr_r);
  assign mag = d[25] ? 26'(-d) : 26'(d);

  // Shared divider.
  logic [cdcn_pkg::DIV_DW-1:0] div_dividend, div_quot;
  logic [cdcn_pkg::DIV_VW-1:0] div_divisor;
  logic                        div_done;

  logic signed [47:0] acc_q [COEFFS];
  logic signed [39:0] ws_q;
  logic signed [47:0] acc_sel;
  logic [47:0]        acc_mag;
  logic [39:0]        ws_mag;

  assign acc_sel = acc_q[j_q];
  assign acc_mag = acc_sel[47] ? 48'(-acc_sel) : 48'(acc_sel);
  assign ws_mag  = ws_q[39] ? 40'(-ws_q) : 40'(ws_q);

  always_comb begin
    if (cmd_i.div_out) begin
      div_dividend = {acc_mag, 16'd0};
      div_divisor  = ws_mag;
    end else begin
      div_dividend = {12'd0, sq_q};
      div_divisor  = (var_r == 24'd0) ? 40'd1 : {16'd0, var_r};
    end
  end

  cdcn_div #(.DW(cdcn_pkg::DIV_DW), .VW(cdcn_pkg::DIV_VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_term | cmd_i.div_out),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Exponent, codeword weight and estimate.
  logic [DIST_W-1:0]        dist_q;
  logic [DIST_W-18:0]       hi;
  logic [33:0]              e_prod;
  logic [16:0]              e_q;
  logic signed [41:0]       ew;
  logic signed [25:0]       fk_q;
  logic signed [25:0]       v;
  logic signed [51:0]       prod_q;

  assign hi     = dist_q[DIST_W-1:17];
  assign e_prod = cdcn_pkg::exp_int(hi[3:0]) * cdcn_pkg::exp_frac(dist_q[16:13]);
  assign ew     = $signed({1'b0, e_q}) * wt_r;
  assign v      = 26'(z) - 26'(t) - 26'(corr_r);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= mag * mag;
    end
    if (cmd_i.clr) begin
      dist_q <= '0;
    end else if (cmd_i.dist_add) begin
      dist_q <= dist_q + DIST_W'(div_quot);
    end else if (cmd_i.ws_add) begin
      dist_q <= '0;
    end
    if (cmd_i.exp_en) begin
      e_q <= (hi > (DIST_W-17)'(11)) ? 17'd0 : 17'((e_prod + 34'd32768) >> 16);
    end
    if (cmd_i.fk_en) begin
      fk_q <= 26'(cdcn_pkg::round16(64'(ew)));
    end
    if (cmd_i.prod_en) begin
      prod_q <= v * fk_q;
    end
    if (cmd_i.clr) begin
      ws_q <= '0;
    end else if (cmd_i.ws_add) begin
      ws_q <= ws_q + 40'(fk_q);
    end
    for (int i = 0; i < COEFFS; i++) begin
      if (cmd_i.clr) begin
        acc_q[i] <= '0;
      end else if (cmd_i.acc_add && (j_q == CW'(i))) begin
        acc_q[i] <= acc_q[i] + 48'(cdcn_pkg::round16(64'(prod_q)));
      end
    end
  end

  // Result value selection and saturation.
  logic signed [24:0] zt;
  logic signed [23:0] zt_sat, q_sat, res;
  logic               neg;

  assign zt  = 25'(z) - 25'(t);
  assign neg = acc_sel[47] ^ ws_q[39];

  always_comb begin
    if (zt > 25'sd8388607) begin
      zt_sat = 24'sh7FFFFF;
    end else if (zt < -25'sd8388608) begin
      zt_sat = 24'sh800000;
    end else begin
      zt_sat = zt[23:0];
    end
    if (!neg) begin
      q_sat = (div_quot > 64'd8388607) ? 24'sh7FFFFF : div_quot[23:0];
    end else begin
      q_sat = (div_quot > 64'd8388608) ? 24'sh800000 : 24'(~div_quot[23:0] + 24'd1);
    end
    if (!en_i) begin
      res = z;
    end else if (ws_q == 40'sd0) begin
      res = zt_sat;
    end else begin
      res = q_sat;
    end
  end

  // Output register.
  logic               out_valid_q;
  logic [3:0]         out_index_q;
  logic signed [23:0] out_value_q;
  logic               out_last_q;
  logic               j_last;

  assign j_last = (j_q == CW'(COEFFS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= 4'(j_q);
      out_value_q <= res;
      out_last_q  <= j_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  assign stat_o.en       = en_i;
  assign stat_o.ws_zero  = (ws_q == 40'sd0);
  assign stat_o.j_last   = j_last;
  assign stat_o.k_zero   = (k_q == '0);
  assign stat_o.k_last   = (k_q == nm1);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

/* design/cdcn_ctrl.sv */
// Controller: sequences table loads, the per-codeword passes and result delivery.
`default_nettype none
module cdcn_ctrl #(
  parameter int unsigned COEFFS    = 13,
  parameter int unsigned MAX_CODES = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      func_i,
  input  wire logic [5:0]      code_index_i,
  input  wire logic [3:0]      coef_index_i,
  input  wire cdcn_pkg::stat_t stat_i,
  output cdcn_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_D_RD, S_D_MUL, S_D_DIV, S_D_WAIT, S_EXP, S_FK, S_WSUM,
    S_A_RD, S_A_MUL, S_A_ADD, S_NEXT, S_O_START, S_O_WAIT, S_O_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   coef_ok, code_ok;

  assign coef_ok = 32'(coef_index_i) < 32'(COEFFS);
  assign code_ok = 32'(code_index_i) < 32'(MAX_CODES);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && coef_ok) begin
          unique case (cdcn_pkg::func_e'(func_i))
            cdcn_pkg::FUNC_LOAD_COEF:   cmd_o.wr_tab  = code_ok;
            cdcn_pkg::FUNC_LOAD_WEIGHT: cmd_o.wr_wt   = code_ok;
            cdcn_pkg::FUNC_LOAD_TILT:   cmd_o.wr_tilt = 1'b1;
            cdcn_pkg::FUNC_FRAME: begin
              cmd_o.wr_frame = 1'b1;
              if (32'(coef_index_i) == 32'(COEFFS - 1)) begin
                cmd_o.clr = 1'b1;
                state_d   = stat_i.en ? S_D_RD : S_O_START;
              end
            end
            default: ;
          endcase
        end
      end
      S_D_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_D_MUL;
      end
      S_D_MUL: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_D_DIV;
      end
      S_D_DIV: begin
        cmd_o.div_term = 1'b1;
        state_d        = S_D_WAIT;
      end
      S_D_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.dist_add = 1'b1;
          if (stat_i.j_last) begin
            cmd_o.j_clr = 1'b1;
            state_d     = S_EXP;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = S_D_RD;
          end
        end
      end
      S_EXP: begin
        cmd_o.exp_en = 1'b1;
        state_d      = S_FK;
      end
      S_FK: begin
        cmd_o.fk_en = 1'b1;
        state_d     = S_WSUM;
      end
      S_WSUM: begin
        cmd_o.ws_add = 1'b1;
        state_d      = stat_i.k_zero ? S_NEXT : S_A_RD;
      end
      S_A_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_A_MUL;
      end
      S_A_MUL: begin
        cmd_o.prod_en = 1'b1;
        state_d       = S_A_ADD;
      end
      S_A_ADD: begin
        cmd_o.acc_add = 1'b1;
        if (stat_i.j_last) begin
          cmd_o.j_clr = 1'b1;
          state_d     = S_NEXT;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_A_RD;
        end
      end
      S_NEXT: begin
        if (stat_i.k_last) begin
          state_d = S_O_START;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_D_RD;
        end
      end
      S_O_START: begin
        if (stat_i.en && !stat_i.ws_zero) begin
          cmd_o.div_out = 1'b1;
          state_d       = S_O_WAIT;
        end else begin
          state_d = S_O_LOAD;
        end
      end
      S_O_WAIT: begin
        if (stat_i.div_done) begin
          state_d = S_O_LOAD;
        end
      end
      S_O_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.j_last) begin
            cmd_o.j_clr = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = S_O_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/cepstral_codebook_noise_normalizer_top.sv */
// Load words are written as the idle controller takes them; the last frame word
// starts a frame pass. Enabled frame: per codeword, a 64-step divider run for each
// coefficient's distance term, then exponent, weight and sum steps, and for every
// codeword but the first an estimate update; then one division per result word.
// The shared divider sets the pace of an enabled frame; a disabled one needs none.
// Reset (async, active low) clears control and sets active_codes=64, enable=0, ready=0.
`default_nettype none
module cepstral_codebook_noise_normalizer_top #(
  parameter int unsigned COEFFS    = 13,
  parameter int unsigned MAX_CODES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input word channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [5:0]         code_index_i,
  input  wire logic [3:0]         coef_index_i,
  input  wire logic signed [23:0] value_a_i,
  input  wire logic signed [23:0] value_b_i,
  input  wire logic [23:0]        value_c_i,
  // Result word channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              out_index_o,
  output logic signed [23:0]      out_value_o,
  output logic                    out_last_o,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [6:0]         cfg_data_i
);

  // Configuration registers. Writes are always taken; software must change them only
  // while the block is idle, which the block itself does not enforce or hold off.
  logic [6:0] active_codes_q;
  logic       enable_q;
  logic       stats_ready_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_codes_q <= 7'd64;
      enable_q       <= 1'b0;
      stats_ready_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cdcn_pkg::CFG_ACTIVE_CODES: active_codes_q <= cfg_data_i;
        cdcn_pkg::CFG_ENABLE:       enable_q       <= cfg_data_i[0];
        cdcn_pkg::CFG_STATS_READY:  stats_ready_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Normalization runs only when it is enabled and the tables are marked
  // loaded; otherwise each frame word passes through untouched.
  logic en;
  assign en = enable_q & stats_ready_q;

  cdcn_pkg::cmd_t  cmd;
  cdcn_pkg::stat_t stat;

  // The controller walks codewords and coefficients; it accepts a new input
  // word only while idle, but the result register lets the last result of a
  // frame wait for the sink while the next word is already taken.
  cdcn_ctrl #(.COEFFS(COEFFS), .MAX_CODES(MAX_CODES)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .code_index_i (code_index_i),
    .coef_index_i (coef_index_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // The datapath holds the codebook RAMs, the frame and tilt registers, the
  // accumulators, one multiplier stage per product and a shared divider.
  cdcn_dp #(.COEFFS(COEFFS), .MAX_CODES(MAX_CODES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .en_i           (en),
    .active_codes_i (active_codes_q),
    .code_index_i   (code_index_i),
    .coef_index_i   (coef_index_i),
    .value_a_i      (value_a_i),
    .value_b_i      (value_b_i),
    .value_c_i      (value_c_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .out_last_o     (out_last_o)
  );

`ifndef NO_ASSERTIONS
  // The last flag marks the final coefficient only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (out_index_o == 4'(COEFFS - 1)))
    else $error("last flag on a coefficient other than the final one");

  // The divider never finishes while the controller is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> !in_ready_o)
    else $error("divider completed outside a frame pass");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");
`endif

endmodule
`default_nettype wire

/* verif/cepstral_codebook_noise_normalizer_top_tb.sv */
// Self-checking testbench for the cepstral codebook noise normalizer top level.
`timescale 1ns / 100ps
`default_nettype none
module cepstral_codebook_noise_normalizer_top_tb;

  localparam int NCOEF = 13;
  localparam int NCODE = 64;
  // The configuration index that names no register; writes to it must be harmless.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // Integer and fraction exponent steps in Q1.16.
  localparam longint unsigned EXP_INT_Q16 [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                                  162, 60, 22, 8, 3, 1};
  localparam longint unsigned EXP_FRAC_Q16 [16] = '{65536, 61565, 57835, 54331, 51039,
                                                   47947, 45042, 42313, 39750, 37341,
                                                   35079, 32954, 30957, 29082, 27319,
                                                   25664};

  typedef struct {
    logic [3:0]         index;
    logic signed [23:0] value;
    logic               last;
  } clean_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i = '0;
  logic [5:0]         code_index_i = '0;
  logic [3:0]         coef_index_i = '0;
  logic signed [23:0] value_a_i = '0;
  logic signed [23:0] value_b_i = '0;
  logic [23:0]        value_c_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         out_index_o;
  logic signed [23:0] out_value_o;
  logic               out_last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [6:0]         cfg_data_i = '0;

  cepstral_codebook_noise_normalizer_top dut (.*);

  always #10 clk_i = ~clk_i;

  // Mirror of the block's state, kept in step with every accepted word.
  logic [6:0]         act_codes_q = 7'd64;
  logic               enable_q = 1'b0;
  logic               ready_q = 1'b0;
  logic signed [23:0] mean_mem [NCODE*NCOEF];
  logic signed [23:0] corr_mem [NCODE*NCOEF];
  logic [23:0]        var_mem [NCODE*NCOEF];
  logic signed [23:0] weight_mem [NCODE];
  logic signed [23:0] tilt_mem [NCOEF];
  logic signed [23:0] frame_mem [NCOEF];

  clean_word_t pending_clean[$];
  int          mismatches = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  int          hold_request = 0;

  function automatic longint round_q16(input longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32768) / 65536);
  endfunction

  function automatic longint sat_q24(input logic signed [95:0] v);
    if (v > 96'sd8388607) return 8388607;
    if (v < -96'sd8388608) return -8388608;
    return longint'(v);
  endfunction

  function automatic longint unsigned gauss_q16(input longint unsigned h);
    longint unsigned i;
    longint unsigned f;
    i = h >> 16;
    f = (h >> 12) & 15;
    if (i >= 12) return 0;
    return (EXP_INT_Q16[i] * EXP_FRAC_Q16[f] + 32768) >> 16;
  endfunction

  // Works out the thirteen cleaned words that the last frame word releases.
  task automatic normalize_frame();
    longint            acc [NCOEF];
    longint            wsum;
    longint            fk;
    longint            d;
    longint unsigned   mag;
    longint unsigned   dv;
    longint unsigned   dsum;
    logic signed [95:0] num;
    int                n;
    int                ad;
    clean_word_t       w;
    bit                norm;
    wsum = 0;
    for (int j = 0; j < NCOEF; j++) acc[j] = 0;
    n = (act_codes_q == 0) ? 1 : (act_codes_q > NCODE) ? NCODE : act_codes_q;
    norm = enable_q && ready_q;
    if (norm) begin
      for (int k = 0; k < n; k++) begin
        dsum = 0;
        for (int j = 0; j < NCOEF; j++) begin
          ad = k * NCOEF + j;
          d = longint'(frame_mem[j]) - tilt_mem[j] - mean_mem[ad] - corr_mem[ad];
          mag = (d < 0) ? -d : d;
          dv = (var_mem[ad] == 0) ? 1 : var_mem[ad];
          dsum += (mag * mag) / dv;
        end
        fk = round_q16(longint'(gauss_q16(dsum >> 1)) * weight_mem[k]);
        // Codeword zero only feeds the denominator.
        if (k > 0) begin
          for (int j = 0; j < NCOEF; j++) begin
            d = longint'(frame_mem[j]) - tilt_mem[j] - corr_mem[k*NCOEF+j];
            acc[j] += round_q16(d * fk);
          end
        end
        wsum += fk;
      end
    end
    for (int j = 0; j < NCOEF; j++) begin
      w.index = 4'(j);
      w.last = (j == NCOEF - 1);
      if (!norm) begin
        w.value = frame_mem[j];
      end else if (wsum == 0) begin
        w.value = 24'(sat_q24(96'(longint'(frame_mem[j]) - tilt_mem[j])));
      end else begin
        num = acc[j];
        num = num * 65536;
        w.value = 24'(sat_q24(num / 96'(wsum)));
      end
      pending_clean.push_back(w);
    end
  endtask

  task automatic apply_word(input cdcn_pkg::func_e f, input int code, input int coef,
                            input logic signed [23:0] a, input logic signed [23:0] b,
                            input logic [23:0] c);
    int ad;
    if (coef >= NCOEF) return;
    ad = code * NCOEF + coef;
    case (f)
      cdcn_pkg::FUNC_LOAD_COEF: begin
        mean_mem[ad] = a;
        corr_mem[ad] = b;
        var_mem[ad] = c;
      end
      cdcn_pkg::FUNC_LOAD_WEIGHT: weight_mem[code] = a;
      cdcn_pkg::FUNC_LOAD_TILT: tilt_mem[coef] = a;
      default: begin
        frame_mem[coef] = a;
        if (coef == NCOEF - 1) normalize_frame();
      end
    endcase
  endtask

  // Offers one word after a random gap and returns at the edge that takes it.
  task automatic send_word(input cdcn_pkg::func_e f, input int code, input int coef,
                           input logic signed [23:0] a, input logic signed [23:0] b,
                           input logic [23:0] c);
    int gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    code_index_i <= 6'(code);
    coef_index_i <= 4'(coef);
    value_a_i <= a;
    value_b_i <= b;
    value_c_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    apply_word(f, code, coef, a, b, c);
  endtask

  // Waits until every expected word is back and the block has gone quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_clean.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      cdcn_pkg::CFG_ACTIVE_CODES: act_codes_q = data;
      cdcn_pkg::CFG_ENABLE:       enable_q = data[0];
      cdcn_pkg::CFG_STATS_READY:  ready_q = data[0];
      default: ;
    endcase
  endtask

  function automatic logic signed [23:0] near_zero(input int span);
    return 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    return 24'(sat_q24(96'(v)));
  endfunction

  task automatic load_codes(input int lo, input int hi);
    for (int k = lo; k <= hi; k++) begin
      for (int j = 0; j < NCOEF; j++)
        send_word(cdcn_pkg::FUNC_LOAD_COEF, k, j, near_zero(65536), near_zero(32768),
                  24'($urandom_range(16384, 1048576)));
      send_word(cdcn_pkg::FUNC_LOAD_WEIGHT, k, 0,
                ($urandom_range(0, 7) == 0) ? near_zero(65536)
                                            : 24'($urandom_range(1, 131072)), '0, '0);
    end
  endtask

  // A frame that sits close to one codeword, so the Gaussian weights stay alive.
  task automatic send_near_frame(input int codes, input int noise);
    int r;
    r = $urandom_range(0, codes - 1);
    for (int j = 0; j < NCOEF; j++)
      send_word(cdcn_pkg::FUNC_FRAME, $urandom_range(0, 63), j,
                clip24(longint'(tilt_mem[j]) + mean_mem[r*NCOEF+j] + corr_mem[r*NCOEF+j] +
                       near_zero(noise)), 24'($urandom), 24'($urandom));
  endtask

  // Receiver: random stalls per word, an optional long hold-off, and the checker.
  int          recv_wait = 0;
  int          hold_left = 0;
  clean_word_t want;
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_clean.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: index %0d value %0d last %0d",
                                       out_index_o, out_value_o, out_last_o);
      end else begin
        want = pending_clean.pop_front();
        if (out_index_o !== want.index || out_value_o !== want.value ||
            out_last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected index %0d value %0d last %0d, got %0d %0d %0d",
                     want.index, want.value, want.last, out_index_o, out_value_o,
                     out_last_o);
        end
      end
      recv_wait = recv_gaps ? $urandom_range(0, 4) : 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Disabled frames pass untouched; the extremes of the sample range go through.
  task automatic test_passthrough();
    logic signed [23:0] edge_vals [4] = '{24'sh7FFFFF, -24'sh800000, 24'sh000000, -24'sh1};
    for (int j = 0; j < NCOEF; j++)
      send_word(cdcn_pkg::FUNC_FRAME, 6'h3F, j, (j < 4) ? edge_vals[j] : near_zero(8388607),
                24'h555555, 24'hAAAAAA);
  endtask

  // Coefficient indexes 13 to 15 are dropped by every function.
  task automatic test_ignored_index();
    for (int f = 0; f < 4; f++)
      send_word(cdcn_pkg::func_e'(f), 6'h2A, NCOEF + f % 3, 24'sh7FFFFF, -24'sh800000,
                24'hFFFFFF);
  endtask

  // Tables with extreme weights and variances, then two normalized frames.
  task automatic test_normalize();
    load_codes(0, 3);
    for (int j = 0; j < NCOEF; j++)
      send_word(cdcn_pkg::FUNC_LOAD_TILT, 0, j, near_zero(32768), '0, '0);
    send_word(cdcn_pkg::FUNC_LOAD_COEF, 2, 0, '0, '0, 24'h000000);
    send_word(cdcn_pkg::FUNC_LOAD_COEF, 2, 1, '0, '0, 24'hFFFFFF);
    send_word(cdcn_pkg::FUNC_LOAD_WEIGHT, 1, 0, 24'sh7FFFFF, '0, '0);
    send_word(cdcn_pkg::FUNC_LOAD_WEIGHT, 3, 0, -24'sh800000, '0, '0);
    write_reg(cdcn_pkg::CFG_ACTIVE_CODES, 7'd4);
    write_reg(cdcn_pkg::CFG_STATS_READY, 7'd1);
    write_reg(cdcn_pkg::CFG_ENABLE, 7'd1);
    send_near_frame(4, 4096);
    send_near_frame(4, 65536);
  endtask

  // Either gate low passes the frame through.
  task automatic test_gates();
    write_reg(cdcn_pkg::CFG_STATS_READY, 7'd0);
    send_near_frame(4, 4096);
    write_reg(cdcn_pkg::CFG_STATS_READY, 7'd1);
    write_reg(cdcn_pkg::CFG_ENABLE, 7'd0);
    send_near_frame(4, 4096);
    write_reg(cdcn_pkg::CFG_ENABLE, 7'd1);
  endtask

  // Zero denominator gives z minus tilt; zero active codes act as one codeword.
  task automatic test_zero_weight();
    logic signed [23:0] keep;
    keep = weight_mem[0];
    send_word(cdcn_pkg::FUNC_LOAD_WEIGHT, 0, 0, '0, '0, '0);
    write_reg(cdcn_pkg::CFG_ACTIVE_CODES, 7'd0);
    send_near_frame(1, 1024);
    send_word(cdcn_pkg::FUNC_LOAD_WEIGHT, 0, 0, keep, '0, '0);
    send_near_frame(1, 1024);
    write_reg(cdcn_pkg::CFG_ACTIVE_CODES, 7'd1);
    send_near_frame(1, 1024);
  endtask

  // The last coefficient arriving early fires on whatever the buffer holds.
  task automatic test_out_of_order();
    write_reg(cdcn_pkg::CFG_ACTIVE_CODES, 7'd3);
    send_word(cdcn_pkg::FUNC_FRAME, 0, NCOEF - 1, near_zero(65536), '0, '0);
    send_word(cdcn_pkg::FUNC_FRAME, 0, 3, near_zero(65536), '0, '0);
    send_word(cdcn_pkg::FUNC_FRAME, 0, 7, near_zero(65536), '0, '0);
    send_word(cdcn_pkg::FUNC_FRAME, 0, NCOEF - 1, near_zero(65536), '0, '0);
  endtask

  // The receiver holds off while disabled frames keep coming, then the sender waits.
  task automatic test_backpressure();
    write_reg(cdcn_pkg::CFG_ENABLE, 7'd0);
    hold_request = 3000;
    send_gaps = 1'b0;
    repeat (2) send_near_frame(4, 65536);
    send_gaps = 1'b1;
    drain();
    recv_gaps = 1'b0;
    send_near_frame(4, 65536);
    recv_gaps = 1'b1;
    write_reg(cdcn_pkg::CFG_ENABLE, 7'd1);
  endtask

  // Mostly well-formed frames with random content, mixed with noise words.
  task automatic test_random();
    for (int p = 0; p < 3; p++) begin
      write_reg(cdcn_pkg::CFG_ACTIVE_CODES, 7'($urandom_range(1, 4)));
      write_reg(cdcn_pkg::CFG_ENABLE, 7'($urandom_range(0, 3) != 0));
      write_reg(cdcn_pkg::CFG_STATS_READY, 7'($urandom_range(0, 3) != 0));
      send_gaps = (p != 2);
      recv_gaps = (p != 1);
      if ($urandom_range(0, 2) == 0)
        send_word(cdcn_pkg::func_e'($urandom_range(0, 3)), $urandom_range(0, 63),
                  $urandom_range(0, 15), 24'($urandom), 24'($urandom), 24'($urandom));
      if ($urandom_range(0, 3) == 0)
        send_word(cdcn_pkg::FUNC_LOAD_COEF, $urandom_range(0, 3), $urandom_range(0, 12),
                  near_zero(65536), near_zero(32768), 24'($urandom_range(0, 16777215)));
      send_near_frame(4, ($urandom_range(0, 1) == 0) ? 8192 : 131072);
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // The codeword count written past its maximum and a write to the spare index,
  // followed by a pass-through frame.
  task automatic test_all_codes();
    write_reg(CFG_SPARE, 7'h7F);
    write_reg(cdcn_pkg::CFG_ENABLE, 7'd0);
    write_reg(cdcn_pkg::CFG_ACTIVE_CODES, 7'd127);
    send_near_frame(4, 8192);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_ignored_index();
    test_normalize();
    test_gates();
    test_zero_weight();
    test_out_of_order();
    test_backpressure();
    test_random();
    test_all_codes();
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_clean.size() == 0) begin
      $display("[cepstral_codebook_noise_normalizer_top] OK");
    end else begin
      $display("[cepstral_codebook_noise_normalizer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("[cepstral_codebook_noise_normalizer_top] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
